// ===== rtl/core/pmss_pkg.sv =====
package pmss_pkg;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_DET_RPT = 3'd3;
  localparam logic [2:0] MODE_CON_RPT = 3'd4;

  localparam logic [1:0] DET_NONE  = 2'd0;
  localparam logic [1:0] DET_PLUS  = 2'd1;
  localparam logic [1:0] DET_MINUS = 2'd2;

  localparam logic [1:0] DIR_STOP  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd2;

  localparam logic [1:0] RES_NORMAL = 2'd0;
  localparam logic [1:0] RES_ACTIVE = 2'd1;
  localparam logic [1:0] RES_FAILED = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DETECTOR  = 3'd1;
  localparam logic [2:0] ERR_CONTACT   = 3'd2;
  localparam logic [2:0] ERR_NOT_HALT  = 3'd3;
  localparam logic [2:0] ERR_BAD_STATE = 3'd4;

  localparam logic [1:0] CFG_DETECT_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_CONTACT_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_SHUTDOWN_TIMEOUT = 2'd2;

  localparam logic [15:0] DETECT_TIMEOUT_RST   = 16'd300;
  localparam logic [15:0] CONTACT_TIMEOUT_RST  = 16'd200;
  localparam logic [15:0] SHUTDOWN_TIMEOUT_RST = 16'd300;

  typedef struct packed {
    logic [2:0]  mode;
    logic        target_plus;
    logic [15:0] throw_limit;
    logic        bench_mode;
    logic [1:0]  detector_setting;
    logic [1:0]  sensed_position;
    logic [1:0]  contact_setting;
    logic        motor_running;
    logic        motor_fault;
    logic [15:0] motor_elapsed;
  } pmss_in_t;

  typedef struct packed {
    logic [1:0]  detect_request;
    logic [1:0]  contact_request;
    logic        motor_start;
    logic        motor_direction;
    logic        motor_bench;
    logic        motor_stop;
    logic        busy_res;
    logic [15:0] last_duration;
    logic [1:0]  outcome;
    logic [2:0]  error_code;
  } pmss_out_t;

  typedef struct packed {
    logic [15:0] detect_timeout;
    logic [15:0] contact_timeout;
    logic [15:0] shutdown_timeout;
  } pmss_cfg_t;

endpackage

// ===== rtl/core/point_machine_shift_sequencer.sv =====
// A word is captured in the input register, and its result in the result register.
// Throughput: one word per cycle unless the output stalls; the input and result
// registers decouple the two sides, so a stalled result does not stop intake at once.
// Reset: asynchronous, active low; the sequencer returns to stopped with all
// status cleared and the timeouts at 300, 200 and 300 ticks.
module point_machine_shift_sequencer import pmss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pmss_in_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pmss_out_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic      in_valid_q;
  pmss_in_t  in_word_q;
  logic      out_valid_q;
  pmss_out_t out_word_q;
  pmss_cfg_t cfg_q;
  pmss_out_t res;
  logic      advance;
  logic      fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  pmss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .word_i (in_word_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_timeout   <= DETECT_TIMEOUT_RST;
      cfg_q.contact_timeout  <= CONTACT_TIMEOUT_RST;
      cfg_q.shutdown_timeout <= SHUTDOWN_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DETECT_TIMEOUT:   cfg_q.detect_timeout   <= cfg_wdata_i;
        CFG_CONTACT_TIMEOUT:  cfg_q.contact_timeout  <= cfg_wdata_i;
        CFG_SHUTDOWN_TIMEOUT: cfg_q.shutdown_timeout <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/core/pmss_seq.sv =====
module pmss_seq import pmss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  pmss_in_t  word_i,
  input  pmss_cfg_t cfg_i,
  output pmss_out_t res_o
);

  typedef enum logic [2:0] {
    PH_STOPPED   = 3'd0,
    PH_INIT_DET  = 3'd1,
    PH_PREP      = 3'd2,
    PH_RUNNING   = 3'd3,
    PH_SHUTDOWN  = 3'd4,
    PH_FINAL_DET = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        enabled_q, enabled_d;
  logic        goal_plus_q, goal_plus_d;
  logic        bench_q, bench_d;
  logic [15:0] run_limit_q, run_limit_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] wait_dec;
  logic [1:0]  want_det_q, want_det_d;
  logic [1:0]  rep_det_q, rep_det_d;
  logic [1:0]  rep_pos_q, rep_pos_d;
  logic [1:0]  want_con_q, want_con_d;
  logic [1:0]  rep_con_q, rep_con_d;
  logic [1:0]  result_q, result_d;
  logic [15:0] duration_q, duration_d;
  logic        start, stop;
  logic [2:0]  err;
  logic        at_goal;

  assign wait_dec = (wait_q != 16'd0) ? wait_q - 16'd1 : wait_q;
  assign at_goal  = (goal_plus_q && rep_pos_q == DET_PLUS) ||
                    (!goal_plus_q && rep_pos_q == DET_MINUS);

  always_comb begin
    phase_d     = phase_q;
    enabled_d   = enabled_q;
    goal_plus_d = goal_plus_q;
    bench_d     = bench_q;
    run_limit_d = run_limit_q;
    wait_d      = wait_q;
    want_det_d  = want_det_q;
    rep_det_d   = rep_det_q;
    rep_pos_d   = rep_pos_q;
    want_con_d  = want_con_q;
    rep_con_d   = rep_con_q;
    result_d    = result_q;
    duration_d  = duration_q;
    start       = 1'b0;
    stop        = 1'b0;
    err         = ERR_NONE;
    unique case (word_i.mode)
      MODE_TICK: begin
        wait_d = wait_dec;
        unique case (phase_q)
          PH_STOPPED: begin
            if (enabled_q) begin
              want_det_d = goal_plus_q ? DET_PLUS : DET_MINUS;
              rep_det_d  = DET_NONE;
              rep_pos_d  = DET_NONE;
              want_con_d = DIR_STOP;
              rep_con_d  = DIR_STOP;
              wait_d     = cfg_i.detect_timeout;
              phase_d    = PH_INIT_DET;
            end
          end
          PH_INIT_DET: begin
            if (wait_dec == 16'd0) begin
              if (rep_det_q == want_det_q) begin
                if (at_goal) begin
                  enabled_d = 1'b0;
                  phase_d   = PH_STOPPED;
                end else begin
                  want_det_d = DET_NONE;
                  want_con_d = goal_plus_q ? DIR_PLUS : DIR_MINUS;
                  wait_d     = cfg_i.contact_timeout;
                  phase_d    = PH_PREP;
                end
              end else begin
                err = ERR_DETECTOR;
              end
            end
          end
          PH_PREP: begin
            if (wait_dec == 16'd0) begin
              if (rep_con_q == want_con_q) begin
                start    = 1'b1;
                result_d = RES_ACTIVE;
                wait_d   = run_limit_q;
                phase_d  = PH_RUNNING;
              end else begin
                err = ERR_CONTACT;
              end
            end
          end
          PH_RUNNING: begin
            if (wait_dec == 16'd0 || word_i.motor_fault || !enabled_q) begin
              duration_d = word_i.motor_elapsed;
              stop       = 1'b1;
              wait_d     = cfg_i.shutdown_timeout;
              phase_d    = PH_SHUTDOWN;
            end
          end
          PH_SHUTDOWN: begin
            if (wait_dec == 16'd0) begin
              if (!word_i.motor_running) begin
                want_det_d = goal_plus_q ? DET_PLUS : DET_MINUS;
                rep_det_d  = DET_NONE;
                rep_pos_d  = DET_NONE;
                want_con_d = DIR_STOP;
                rep_con_d  = DIR_STOP;
                wait_d     = cfg_i.detect_timeout;
                phase_d    = PH_FINAL_DET;
              end else begin
                err = ERR_NOT_HALT;
              end
            end
          end
          PH_FINAL_DET: begin
            if (wait_dec == 16'd0) begin
              if (rep_det_q == want_det_q) begin
                result_d  = at_goal ? RES_NORMAL : RES_FAILED;
                enabled_d = 1'b0;
                phase_d   = PH_STOPPED;
              end else begin
                err = ERR_DETECTOR;
              end
            end
          end
          default: begin
            err = ERR_BAD_STATE;
          end
        endcase
      end
      MODE_START: begin
        if (phase_q == PH_STOPPED) begin
          goal_plus_d = word_i.target_plus;
          run_limit_d = word_i.throw_limit;
          bench_d     = word_i.bench_mode;
          enabled_d   = 1'b1;
        end
      end
      MODE_STOP: begin
        enabled_d = 1'b0;
      end
      MODE_DET_RPT: begin
        rep_det_d = word_i.detector_setting;
        rep_pos_d = word_i.sensed_position;
      end
      MODE_CON_RPT: begin
        rep_con_d = word_i.contact_setting;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.detect_request  = want_det_d;
    res_o.contact_request = want_con_d;
    res_o.motor_start     = start;
    res_o.motor_direction = start & goal_plus_d;
    res_o.motor_bench     = start & bench_d;
    res_o.motor_stop      = stop;
    res_o.busy_res        = (phase_d != PH_STOPPED);
    res_o.last_duration   = duration_d;
    res_o.outcome         = result_d;
    res_o.error_code      = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STOPPED;
      enabled_q   <= 1'b0;
      goal_plus_q <= 1'b0;
      bench_q     <= 1'b0;
      run_limit_q <= 16'd0;
      wait_q      <= 16'd0;
      want_det_q  <= DET_NONE;
      rep_det_q   <= DET_NONE;
      rep_pos_q   <= DET_NONE;
      want_con_q  <= DIR_STOP;
      rep_con_q   <= DIR_STOP;
      result_q    <= RES_NORMAL;
      duration_q  <= 16'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      enabled_q   <= enabled_d;
      goal_plus_q <= goal_plus_d;
      bench_q     <= bench_d;
      run_limit_q <= run_limit_d;
      wait_q      <= wait_d;
      want_det_q  <= want_det_d;
      rep_det_q   <= rep_det_d;
      rep_pos_q   <= rep_pos_d;
      want_con_q  <= want_con_d;
      rep_con_q   <= rep_con_d;
      result_q    <= result_d;
      duration_q  <= duration_d;
    end
  end

endmodule

// ===== rtl/core/pmss_checker.sv =====
module pmss_checker import pmss_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input pmss_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_start_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.motor_start && out_word_o.motor_stop))
    else $error("motor start and stop in one word");

  a_start_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.motor_start |->
      !out_word_o.motor_direction && !out_word_o.motor_bench)
    else $error("motor direction or bench without start");

  a_idle_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.busy_res |-> out_word_o.outcome != RES_ACTIVE)
    else $error("active outcome while stopped");

  a_err_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error_code != ERR_NONE |-> out_word_o.busy_res)
    else $error("error reported while stopped");

endmodule

bind point_machine_shift_sequencer pmss_checker u_pmss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
